@@ rtl/spi_flash_command_sequencer_macros.svh @@
// assertion helpers shared by the sequencer rtl
`ifndef SPI_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// next-cycle implication, checked outside reset
`define SFCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

@@ rtl/sfcs_pkg.sv @@
`default_nettype none

package sfcs_pkg;

  typedef enum logic [3:0] {
    OP_WREN      = 4'd0,
    OP_WRDI      = 4'd1,
    OP_RDID      = 4'd2,
    OP_RDSR      = 4'd3,
    OP_WRSR      = 4'd4,
    OP_READ      = 4'd5,
    OP_PP        = 4'd6,
    OP_SE        = 4'd7,
    OP_BE        = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ACT_SELECT  = 2'd0,
    ACT_SHIFT   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_REPORT  = 2'd3
  } act_e;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_PRE_WREN  = 6'b000010,
    PH_HDR       = 6'b000100,
    PH_DATA      = 6'b001000,
    PH_POLL_CMD  = 6'b010000,
    PH_POLL_DATA = 6'b100000
  } phase_e;

  localparam logic [7:0] CMD_WREN = 8'h06;
  localparam logic [7:0] CMD_WRDI = 8'h04;
  localparam logic [7:0] CMD_RDID = 8'h9F;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_WRSR = 8'h01;
  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] CMD_PP   = 8'h02;
  localparam logic [7:0] CMD_SE   = 8'hD8;
  localparam logic [7:0] CMD_BE   = 8'hC7;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    act_e       action;
    logic [7:0] tx_byte;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done_res;
    logic       last;
  } res_t;

  function automatic logic [7:0] opcode_of(input op_e op);
    logic [7:0] code;
    case (op)
      OP_WREN: code = CMD_WREN;
      OP_WRDI: code = CMD_WRDI;
      OP_RDID: code = CMD_RDID;
      OP_RDSR: code = CMD_RDSR;
      OP_WRSR: code = CMD_WRSR;
      OP_READ: code = CMD_READ;
      OP_PP:   code = CMD_PP;
      OP_SE:   code = CMD_SE;
      OP_BE:   code = CMD_BE;
      default: code = CMD_WREN;
    endcase
    return code;
  endfunction

  function automatic logic is_write(input op_e op);
    return op inside {OP_WRSR, OP_PP, OP_SE, OP_BE};
  endfunction

  function automatic logic is_read(input op_e op);
    return op inside {OP_RDID, OP_RDSR, OP_READ};
  endfunction

  function automatic logic has_addr(input op_e op);
    return op inside {OP_READ, OP_PP, OP_SE};
  endfunction

  function automatic res_t mk_res(input act_e a, input logic [7:0] tx, input logic [7:0] rd,
                                  input logic rv, input logic dn);
    res_t r;
    r.action     = a;
    r.tx_byte    = tx;
    r.read_byte  = rd;
    r.read_valid = rv;
    r.done_res   = dn;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/spi_flash_command_sequencer.sv @@
// channel | direction | handshake              | fields
// in      | to block  | in_valid_i / in_stall_o | cmd, op, address, length, payload_byte, rx_byte
// out     | from block| out_valid_o/ out_stall_i| action, tx_byte, read_byte, read_valid,
//         |           |                         | done_res, last
// an accepted transaction is decoded in the same cycle and its zero, one or two results
// are written into a four-entry result queue at that edge
// one result leaves per cycle while out_stall_i is low
// in_stall_o rises when fewer than two queue entries are free
// rst_ni clears the sequencer state and empties the queue
`default_nettype none

`include "spi_flash_command_sequencer_macros.svh"

module spi_flash_command_sequencer #(
  parameter int unsigned MAX_LEN  = 65535,
  parameter int unsigned ID_BYTES = 19
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [3:0]  op_i,
  input  logic [23:0] address_i,
  input  logic [15:0] length_i,
  input  logic [7:0]  payload_byte_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [7:0]  tx_byte_o,
  output logic [7:0]  read_byte_o,
  output logic        read_valid_o,
  output logic        done_res_o,
  output logic        last_o
);
  import sfcs_pkg::*;

  phase_e      phase_q, phase_d;
  op_e         op_q, op_d;
  logic [23:0] addr_q, addr_d;
  logic [15:0] left_q, left_d;
  logic [2:0]  hdr_q, hdr_d;
  logic [7:0]  status_q, status_d;

  res_t        fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  logic        in_acc, pop;
  res_t        res0, res1;
  logic [1:0]  n_push;

  assign in_stall_o  = cnt_q > CntW'(FifoDepth - 2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    logic [15:0] len_sat;
    logic [15:0] left_dec;
    logic [7:0]  data_tx;
    logic [7:0]  addr_byte;
    logic        fin;

    phase_d  = phase_q;
    op_d     = op_q;
    addr_d   = addr_q;
    left_d   = left_q;
    hdr_d    = hdr_q;
    status_d = status_q;
    res0     = mk_res(ACT_SELECT, 8'h00, 8'h00, 1'b0, 1'b0);
    res1     = res0;
    n_push   = 2'd0;
    fin      = 1'b0;

    len_sat  = (32'(length_i) > MAX_LEN) ? 16'(MAX_LEN) : length_i;
    left_dec = (left_q != '0) ? 16'(left_q - 16'd1) : 16'd0;
    if (op_q == OP_PP) begin
      data_tx = payload_byte_i;
    end else if (op_q == OP_WRSR) begin
      data_tx = status_q;
    end else begin
      data_tx = 8'h00;
    end
    case (hdr_q)
      3'd1:    addr_byte = addr_q[23:16];
      3'd2:    addr_byte = addr_q[15:8];
      default: addr_byte = addr_q[7:0];
    endcase

    if (in_acc) begin
      if (!cmd_i) begin
        if (phase_q == PH_IDLE && op_i <= OP_BE) begin
          op_d   = op_e'(op_i);
          addr_d = address_i;
          if (op_e'(op_i) == OP_WRSR) begin
            status_d = payload_byte_i;
          end
          case (op_e'(op_i))
            OP_RDID:         left_d = 16'(ID_BYTES);
            OP_RDSR, OP_WRSR: left_d = 16'd1;
            OP_READ, OP_PP:  left_d = len_sat;
            default:         left_d = 16'd0;
          endcase
          n_push = 2'd1;
          if (is_write(op_e'(op_i))) begin
            res0    = mk_res(ACT_SELECT, CMD_WREN, 8'h00, 1'b0, 1'b0);
            phase_d = PH_PRE_WREN;
          end else begin
            res0    = mk_res(ACT_SELECT, opcode_of(op_e'(op_i)), 8'h00, 1'b0, 1'b0);
            hdr_d   = 3'd1;
            phase_d = PH_HDR;
          end
        end
      end else begin
        case (phase_q)
          PH_PRE_WREN: begin
            res0    = mk_res(ACT_RELEASE, 8'h00, 8'h00, 1'b0, 1'b0);
            res1    = mk_res(ACT_SELECT, opcode_of(op_q), 8'h00, 1'b0, 1'b0);
            n_push  = 2'd2;
            hdr_d   = 3'd1;
            phase_d = PH_HDR;
          end
          PH_HDR: begin
            if (has_addr(op_q) && hdr_q < 3'd4) begin
              res0   = mk_res(ACT_SHIFT, addr_byte, 8'h00, 1'b0, 1'b0);
              n_push = 2'd1;
              hdr_d  = 3'(hdr_q + 3'd1);
            end else if (left_q != '0) begin
              res0    = mk_res(ACT_SHIFT, data_tx, 8'h00, 1'b0, 1'b0);
              n_push  = 2'd1;
              phase_d = PH_DATA;
            end else begin
              fin = 1'b1;
            end
          end
          PH_DATA: begin
            left_d = left_dec;
            n_push = 2'd2;
            if (is_read(op_q)) begin
              if (left_dec != '0) begin
                res0 = mk_res(ACT_REPORT, 8'h00, rx_byte_i, 1'b1, 1'b0);
                res1 = mk_res(ACT_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0);
              end else begin
                res0    = mk_res(ACT_RELEASE, 8'h00, 8'h00, 1'b0, 1'b0);
                res1    = mk_res(ACT_REPORT, 8'h00, rx_byte_i, 1'b1, 1'b1);
                phase_d = PH_IDLE;
              end
            end else if (left_dec != '0) begin
              res0   = mk_res(ACT_SHIFT, data_tx, 8'h00, 1'b0, 1'b0);
              n_push = 2'd1;
            end else begin
              fin = 1'b1;
            end
          end
          PH_POLL_CMD: begin
            res0    = mk_res(ACT_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0);
            n_push  = 2'd1;
            phase_d = PH_POLL_DATA;
          end
          PH_POLL_DATA: begin
            res0   = mk_res(ACT_RELEASE, 8'h00, 8'h00, 1'b0, 1'b0);
            n_push = 2'd2;
            if (rx_byte_i[0]) begin
              res1    = mk_res(ACT_SELECT, CMD_RDSR, 8'h00, 1'b0, 1'b0);
              phase_d = PH_POLL_CMD;
            end else begin
              res1    = mk_res(ACT_REPORT, 8'h00, 8'h00, 1'b0, 1'b1);
              phase_d = PH_IDLE;
            end
          end
          default: n_push = 2'd0;
        endcase
      end
    end

    // main frame done: release, then poll status or report
    if (fin) begin
      res0   = mk_res(ACT_RELEASE, 8'h00, 8'h00, 1'b0, 1'b0);
      n_push = 2'd2;
      if (is_write(op_q)) begin
        res1    = mk_res(ACT_SELECT, CMD_RDSR, 8'h00, 1'b0, 1'b0);
        phase_d = PH_POLL_CMD;
      end else begin
        res1    = mk_res(ACT_REPORT, 8'h00, 8'h00, 1'b0, 1'b1);
        phase_d = PH_IDLE;
      end
    end

    res0.last = n_push == 2'd1;
    res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      op_q     <= OP_WREN;
      addr_q   <= '0;
      left_q   <= '0;
      hdr_q    <= '0;
      status_q <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      addr_q   <= addr_d;
      left_q   <= left_d;
      hdr_q    <= hdr_d;
      status_q <= status_d;
      wr_q     <= PtrW'(wr_q + PtrW'(n_push));
      rd_q     <= PtrW'(rd_q + PtrW'(pop));
      cnt_q    <= CntW'(cnt_q + CntW'(n_push) - CntW'(pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[PtrW'(wr_q + PtrW'(1))] <= res1;
    end
  end

  assign action_o     = fifo_q[rd_q].action;
  assign tx_byte_o    = fifo_q[rd_q].tx_byte;
  assign read_byte_o  = fifo_q[rd_q].read_byte;
  assign read_valid_o = fifo_q[rd_q].read_valid;
  assign done_res_o   = fifo_q[rd_q].done_res;
  assign last_o       = fifo_q[rd_q].last;

  `SFCS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(FifoDepth))
  `SFCS_ASSERT_NOW(a_busy_req_dropped, in_acc && !cmd_i && phase_q != PH_IDLE, n_push == 2'd0)
  `SFCS_ASSERT_NOW(a_pair_last, n_push == 2'd2, !res0.last && res1.last)
  `SFCS_ASSERT_NEXT(a_idle_hold, phase_q == PH_IDLE && !(in_acc && !cmd_i), phase_q == PH_IDLE)
  `SFCS_ASSERT_NOW(a_done_is_report, out_valid_o && done_res_o,
                   action_o == ACT_REPORT && last_o)

endmodule

`default_nettype wire

@@ dv/spi_flash_command_sequencer_test.sv @@
`default_nettype none

module spi_flash_command_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfcs_pkg::*;

  localparam int unsigned ID_COUNT      = 19;
  localparam int unsigned ITEM_TARGET   = 420;
  localparam int unsigned HOLD_CYCLES   = 160;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned REPORT_LIMIT  = 10;

  localparam logic XFER_REQUEST  = 1'b0;
  localparam logic XFER_COMPLETE = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [3:0]  op_i;
  logic [23:0] address_i;
  logic [15:0] length_i;
  logic [7:0]  payload_byte_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  action_o;
  logic [7:0]  tx_byte_o;
  logic [7:0]  read_byte_o;
  logic        read_valid_o;
  logic        done_res_o;
  logic        last_o;

  // sequencer shadow state
  phase_e      seq_phase;
  op_e         cur_op;
  logic [23:0] cur_addr;
  int unsigned bytes_pending;
  logic [2:0]  hdr_idx;
  logic [7:0]  cur_status;

  res_t step_results[$];
  res_t expected_q[$];

  int unsigned useful_items;
  int unsigned results_checked;
  int unsigned failures;
  int unsigned burst_left;
  bit          sender_gaps_on;
  bit          hold_off_req;

  spi_flash_command_sequencer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .op_i           (op_i),
    .address_i      (address_i),
    .length_i       (length_i),
    .payload_byte_i (payload_byte_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .tx_byte_o      (tx_byte_o),
    .read_byte_o    (read_byte_o),
    .read_valid_o   (read_valid_o),
    .done_res_o     (done_res_o),
    .last_o         (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] instruction_of(op_e op);
    case (op)
      OP_WREN: return CMD_WREN;
      OP_WRDI: return CMD_WRDI;
      OP_RDID: return CMD_RDID;
      OP_RDSR: return CMD_RDSR;
      OP_WRSR: return CMD_WRSR;
      OP_READ: return CMD_READ;
      OP_PP:   return CMD_PP;
      OP_SE:   return CMD_SE;
      default: return CMD_BE;
    endcase
  endfunction

  function automatic bit writes_flash(op_e op);
    return op == OP_WRSR || op == OP_PP || op == OP_SE || op == OP_BE;
  endfunction

  function automatic bit reads_flash(op_e op);
    return op == OP_RDID || op == OP_RDSR || op == OP_READ;
  endfunction

  function automatic bit sends_address(op_e op);
    return op == OP_READ || op == OP_PP || op == OP_SE;
  endfunction

  function automatic void emit(act_e a, logic [7:0] tx, logic [7:0] rd, logic rv, logic dn);
    res_t r;
    r.action     = a;
    r.tx_byte    = tx;
    r.read_byte  = rd;
    r.read_valid = rv;
    r.done_res   = dn;
    r.last       = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic logic [7:0] data_byte(logic [7:0] pay);
    if (cur_op == OP_PP) return pay;
    if (cur_op == OP_WRSR) return cur_status;
    return 8'h00;
  endfunction

  // release select, then poll wip or report completion
  function automatic void close_frame();
    emit(ACT_RELEASE, 8'h00, 8'h00, 1'b0, 1'b0);
    if (writes_flash(cur_op)) begin
      emit(ACT_SELECT, CMD_RDSR, 8'h00, 1'b0, 1'b0);
      seq_phase = PH_POLL_CMD;
    end else begin
      emit(ACT_REPORT, 8'h00, 8'h00, 1'b0, 1'b1);
      seq_phase = PH_IDLE;
    end
  endfunction

  function automatic int predict_transaction(logic c, logic [3:0] op, logic [23:0] addr,
                                             logic [15:0] len, logic [7:0] pay,
                                             logic [7:0] rx);
    step_results.delete();
    if (c == XFER_REQUEST) begin
      if (seq_phase == PH_IDLE && op <= OP_BE) begin
        cur_op   = op_e'(op);
        cur_addr = addr;
        if (cur_op == OP_WRSR) cur_status = pay;
        case (cur_op)
          OP_RDID:          bytes_pending = ID_COUNT;
          OP_RDSR, OP_WRSR: bytes_pending = 1;
          OP_READ, OP_PP:   bytes_pending = 32'(len);
          default:          bytes_pending = 0;
        endcase
        if (writes_flash(cur_op)) begin
          emit(ACT_SELECT, CMD_WREN, 8'h00, 1'b0, 1'b0);
          seq_phase = PH_PRE_WREN;
        end else begin
          emit(ACT_SELECT, instruction_of(cur_op), 8'h00, 1'b0, 1'b0);
          hdr_idx   = 3'd1;
          seq_phase = PH_HDR;
        end
      end
    end else begin
      case (seq_phase)
        PH_PRE_WREN: begin
          emit(ACT_RELEASE, 8'h00, 8'h00, 1'b0, 1'b0);
          emit(ACT_SELECT, instruction_of(cur_op), 8'h00, 1'b0, 1'b0);
          hdr_idx   = 3'd1;
          seq_phase = PH_HDR;
        end
        PH_HDR: begin
          if (sends_address(cur_op) && hdr_idx < 3'd4) begin
            case (hdr_idx)
              3'd1:    emit(ACT_SHIFT, cur_addr[23:16], 8'h00, 1'b0, 1'b0);
              3'd2:    emit(ACT_SHIFT, cur_addr[15:8], 8'h00, 1'b0, 1'b0);
              default: emit(ACT_SHIFT, cur_addr[7:0], 8'h00, 1'b0, 1'b0);
            endcase
            hdr_idx = hdr_idx + 3'd1;
          end else if (bytes_pending != 0) begin
            emit(ACT_SHIFT, data_byte(pay), 8'h00, 1'b0, 1'b0);
            seq_phase = PH_DATA;
          end else begin
            close_frame();
          end
        end
        PH_DATA: begin
          if (bytes_pending != 0) bytes_pending--;
          if (reads_flash(cur_op)) begin
            if (bytes_pending != 0) begin
              emit(ACT_REPORT, 8'h00, rx, 1'b1, 1'b0);
              emit(ACT_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0);
            end else begin
              emit(ACT_RELEASE, 8'h00, 8'h00, 1'b0, 1'b0);
              emit(ACT_REPORT, 8'h00, rx, 1'b1, 1'b1);
              seq_phase = PH_IDLE;
            end
          end else if (bytes_pending != 0) begin
            emit(ACT_SHIFT, data_byte(pay), 8'h00, 1'b0, 1'b0);
          end else begin
            close_frame();
          end
        end
        PH_POLL_CMD: begin
          emit(ACT_SHIFT, 8'h00, 8'h00, 1'b0, 1'b0);
          seq_phase = PH_POLL_DATA;
        end
        PH_POLL_DATA: begin
          emit(ACT_RELEASE, 8'h00, 8'h00, 1'b0, 1'b0);
          if (rx[0]) begin
            emit(ACT_SELECT, CMD_RDSR, 8'h00, 1'b0, 1'b0);
            seq_phase = PH_POLL_CMD;
          end else begin
            emit(ACT_REPORT, 8'h00, 8'h00, 1'b0, 1'b1);
            seq_phase = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
    if (step_results.size() != 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_q.push_back(step_results[i]);
    return step_results.size();
  endfunction

  task automatic send_item(logic c, logic [3:0] op, logic [23:0] addr, logic [15:0] len,
                           logic [7:0] pay, logic [7:0] rx);
    int unsigned gap;
    cmd_i          <= c;
    op_i           <= op;
    address_i      <= addr;
    length_i       <= len;
    payload_byte_i <= pay;
    rx_byte_i      <= rx;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_transaction(c, op, addr, len, pay, rx) != 0) useful_items++;
    if (sender_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 6);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // one request, then transfer completions and random noise requests until the sequencer is idle again
  task automatic run_operation(op_e op, logic [23:0] addr, logic [15:0] len, logic [7:0] pay,
                               int unsigned noise_pct, int unsigned wip_pct);
    logic [7:0] rx;
    send_item(XFER_REQUEST, op, addr, len, pay, 8'($urandom));
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(XFER_REQUEST, 4'($urandom), 24'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom));
      end else begin
        rx = 8'($urandom);
        if (seq_phase == PH_POLL_DATA) rx[0] = ($urandom_range(0, 99) < wip_pct);
        send_item(XFER_COMPLETE, 4'($urandom), 24'($urandom), 16'($urandom), 8'($urandom),
                  rx);
      end
    end
  endtask

  task automatic run_random_operation(int unsigned noise_pct, int unsigned wip_pct);
    op_e         op;
    logic [15:0] len;
    int unsigned pick;
    op   = op_e'($urandom_range(0, int'(OP_BE)));
    pick = $urandom_range(0, 99);
    if (op == OP_READ || op == OP_PP) begin
      if (pick < 80) len = 16'($urandom_range(0, 6));
      else if (pick < 97) len = 16'($urandom_range(7, 40));
      else len = 16'($urandom_range(41, 200));
    end else begin
      len = 16'($urandom);
    end
    run_operation(op, 24'($urandom), len, 8'($urandom), noise_pct, wip_pct);
  endtask

  task automatic test_directed();
    send_item(XFER_COMPLETE, 4'hF, 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(XFER_REQUEST, 4'd9, 24'h000000, 16'h0000, 8'h00, 8'h00);
    send_item(XFER_REQUEST, 4'hF, 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    run_operation(OP_WRDI, 24'h000000, 16'h0000, 8'h00, 0, 0);
    run_operation(OP_WREN, 24'hFFFFFF, 16'hFFFF, 8'hFF, 0, 0);
    run_operation(OP_READ, 24'hFFFFFF, 16'h0000, 8'h00, 0, 0);
    run_operation(OP_RDSR, 24'h000000, 16'h0000, 8'h00, 0, 0);
    run_operation(OP_WRSR, 24'h000000, 16'hFFFF, 8'hFF, 30, 60);
  endtask

  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    hold_off_req   = 1'b1;
    repeat (4) run_random_operation(0, 50);
    drain_results();
    run_operation(OP_PP, 24'($urandom), 16'd3, 8'($urandom), 0, 50);
    run_operation(OP_RDID, 24'($urandom), 16'($urandom), 8'($urandom), 0, 0);
    drain_results();
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    while (useful_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_item(XFER_COMPLETE, 4'($urandom), 24'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom));
      end else if (pick < 10) begin
        send_item(XFER_REQUEST, 4'($urandom_range(int'(OP_BE) + 1, 15)), 24'($urandom),
                  16'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        run_random_operation(5, 45);
      end
    end
  endtask

  initial begin : receiver_stall
    int unsigned mode;
    int unsigned run_left;
    int unsigned hold_left;
    mode        = 0;
    run_left    = 0;
    hold_left   = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_stall_i  <= 1'b1;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = $urandom_range(10, 60);
        end
        run_left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 99) < 25);
          2:       out_stall_i <= ($urandom_range(0, 99) < 70);
          default: out_stall_i <= (run_left % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.action     = act_e'(action_o);
      got.tx_byte    = tx_byte_o;
      got.read_byte  = read_byte_o;
      got.read_valid = read_valid_o;
      got.done_res   = done_res_o;
      got.last       = last_o;
      results_checked++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: act %0d tx %02h rd %02h rv %0b dn %0b last %0b",
                   got.action, got.tx_byte, got.read_byte, got.read_valid, got.done_res,
                   got.last);
      end else begin
        want = expected_q.pop_front();
        if (got.action !== want.action || got.tx_byte !== want.tx_byte ||
            got.read_byte !== want.read_byte || got.read_valid !== want.read_valid ||
            got.done_res !== want.done_res || got.last !== want.last) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $write("mismatch: expected act %0d tx %02h rd %02h rv %0b dn %0b last %0b,",
                   want.action, want.tx_byte, want.read_byte, want.read_valid,
                   want.done_res, want.last);
            $display(" got act %0d tx %02h rd %02h rv %0b dn %0b last %0b",
                     got.action, got.tx_byte, got.read_byte, got.read_valid,
                     got.done_res, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    cmd_i          <= XFER_REQUEST;
    op_i           <= 4'd0;
    address_i      <= 24'h000000;
    length_i       <= 16'h0000;
    payload_byte_i <= 8'h00;
    rx_byte_i      <= 8'h00;
    seq_phase       = PH_IDLE;
    cur_op          = OP_WREN;
    cur_addr        = 24'h000000;
    bytes_pending   = 0;
    hdr_idx         = 3'd0;
    cur_status      = 8'h00;
    useful_items    = 0;
    results_checked = 0;
    failures        = 0;
    burst_left      = 0;
    sender_gaps_on  = 1'b1;
    hold_off_req    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("ran %0d transactions with %0d results checked: all nine operations, wip polling,",
             useful_items, results_checked);
    $display("ignored requests and completions, sender gaps and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (failures == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/sfcs_pkg.sv
rtl/spi_flash_command_sequencer.sv
dv/spi_flash_command_sequencer_test.sv
